FILE: design/assert_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tdts_pkg.sv
// shared constants for the tick driven task scheduler
package tdts_pkg;

  // field widths of the request, result and register ports
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned OUT_IDX_W  = 4;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned QUANTUM_W  = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // scheduling policies
  localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_SRTF = 2'd3;

  // request kinds
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // register indexes (paddr word index)
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // register reset values and quantum counter ceiling
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd500;
  localparam logic [QUANTUM_W-1:0] QCOUNT_MAX    = 16'hFFFF;

endpackage

FILE: design/tick_driven_task_scheduler.sv
// Tick-driven task scheduler: task table, ready queue and a scan sequencer.
//
// Requests enter on start/in_* and are taken when start is high and busy is low.
// An arrive request stores the burst under the next task index; the result
// strobes on out_valid in the following cycle and busy stays low, so arrivals
// can be sent back to back. A tick request raises busy while the sequencer
// walks the remaining-time memory through its single read port and one
// comparator; busy then stays high while it does the following:
//   fifo, shortest-remaining and shortest job with nothing running:
//   scan the arrived tasks, one entry a cycle, then read and decrement
//   shortest job with a task already running: read and decrement it
//   round robin: read the queue head, then its remaining time, dropping
//   finished heads, plus one more pass when the quantum rotates the head
// Every result is on out_* for exactly one cycle, marked by out_valid, and
// must be taken then; the receiver cannot stall the block.
// Registers on the APB port: policy at 0x0, quantum at 0x4; pready is always
// high. Reset empties the task table and ready queue, sets policy to fifo and
// quantum to 500. No clearing pass is needed: only written entries are read.
`include "assert_macros.svh"

module tick_driven_task_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [tdts_pkg::BURST_W-1:0]        in_burst_length,
  // result channel
  output logic                                out_valid,
  output logic [tdts_pkg::OUT_IDX_W-1:0]      out_task_index,
  output logic                                out_task_valid,
  output logic                                out_switched,
  output logic                                out_finished,
  output logic [tdts_pkg::OUT_IDX_W-1:0]      out_finished_index,
  output logic                                out_rejected,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdts_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tdts_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tdts_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import tdts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [32:0] TIME_MAX_W = (33'd1 << TIME_BITS) - 33'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_SEL,
    ST_DEC,
    ST_EMPTY,
    ST_RR_CHK,
    ST_RR_QW,
    ST_RR_RW
  } state_t;

  // control and datapath registers
  state_t                 state_r, state_nxt;
  logic [POLICY_W-1:0]    policy_r, policy_nxt;
  logic [QUANTUM_W-1:0]   quantum_r, quantum_nxt;
  logic [CNT_W-1:0]       arrived_count_r, arrived_count_nxt;
  logic [IDX_W-1:0]       q_head_r, q_head_nxt;
  logic [IDX_W-1:0]       q_tail_r, q_tail_nxt;
  logic [CNT_W-1:0]       q_count_r, q_count_nxt;
  logic [QUANTUM_W-1:0]   qcount_r, qcount_nxt;
  logic [IDX_W-1:0]       running_task_r, running_task_nxt;
  logic                   running_valid_r, running_valid_nxt;
  logic [CNT_W-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   found_r, found_nxt;
  logic [TIME_BITS-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]       sel_r, sel_nxt;
  logic                   rotated_r, rotated_nxt;

  // result registers
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]   out_task_index_r, out_task_index_nxt;
  logic                   out_task_valid_r, out_task_valid_nxt;
  logic                   out_switched_r, out_switched_nxt;
  logic                   out_finished_r, out_finished_nxt;
  logic [OUT_IDX_W-1:0]   out_finished_index_r, out_finished_index_nxt;
  logic                   out_rejected_r, out_rejected_nxt;

  // remaining-time memory
  logic [TIME_BITS-1:0]   rem_mem [MAX_TASKS];
  logic                   rem_we, rem_re;
  logic [IDX_W-1:0]       rem_waddr, rem_raddr;
  logic [TIME_BITS-1:0]   rem_wdata, rem_rd_r;

  // ready queue memory
  logic [IDX_W-1:0]       q_mem [MAX_TASKS];
  logic                   q_we, q_re;
  logic [IDX_W-1:0]       q_waddr, q_raddr, q_wdata, q_rd_r;

  logic [BURST_W-1:0]     burst_nz;
  logic [TIME_BITS-1:0]   burst_sat;
  logic [TIME_BITS-1:0]   dec_rem;
  logic                   cfg_wr;
  logic                   cfg_idx;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == IDX_W'(MAX_TASKS - 1)) begin
      r = '0;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

  // handshake and register port
  assign busy    = (state_r != ST_IDLE);
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_POLICY:  prdata = CFG_DATA_W'(policy_r);
      REG_QUANTUM: prdata = CFG_DATA_W'(quantum_r);
      default:     prdata = '0;
    endcase
  end

  // burst clean-up: zero runs one unit, oversize saturates
  always_comb begin
    burst_nz = (in_burst_length == '0) ? BURST_W'(1) : in_burst_length;
    if ({17'd0, burst_nz} > TIME_MAX_W) begin
      burst_sat = TIME_BITS'(TIME_MAX_W);
    end else begin
      burst_sat = TIME_BITS'(burst_nz);
    end
  end

  assign dec_rem = rem_rd_r - 1'b1;

  // memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (rem_re) begin
      rem_rd_r <= rem_mem[rem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_r <= q_mem[q_raddr];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt              = state_r;
    policy_nxt             = policy_r;
    quantum_nxt            = quantum_r;
    arrived_count_nxt      = arrived_count_r;
    q_head_nxt             = q_head_r;
    q_tail_nxt             = q_tail_r;
    q_count_nxt            = q_count_r;
    qcount_nxt             = qcount_r;
    running_task_nxt       = running_task_r;
    running_valid_nxt      = running_valid_r;
    scan_cnt_nxt           = scan_cnt_r;
    rd_pend_nxt            = rd_pend_r;
    rd_idx_nxt             = rd_idx_r;
    found_nxt              = found_r;
    best_nxt               = best_r;
    sel_nxt                = sel_r;
    rotated_nxt            = rotated_r;
    out_valid_nxt          = 1'b0;
    out_task_index_nxt     = out_task_index_r;
    out_task_valid_nxt     = out_task_valid_r;
    out_switched_nxt       = out_switched_r;
    out_finished_nxt       = out_finished_r;
    out_finished_index_nxt = out_finished_index_r;
    out_rejected_nxt       = out_rejected_r;
    rem_we    = 1'b0;
    rem_waddr = '0;
    rem_wdata = '0;
    rem_re    = 1'b0;
    rem_raddr = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_re      = 1'b0;
    q_raddr   = '0;

    // register writes
    if (cfg_wr) begin
      case (cfg_idx)
        REG_POLICY:  policy_nxt = pwdata[POLICY_W-1:0];
        REG_QUANTUM: quantum_nxt = pwdata[QUANTUM_W-1:0];
        default:     policy_nxt = policy_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start && in_req_type == REQ_ARRIVE) begin
          // arrival: store burst, queue the new index
          out_valid_nxt          = 1'b1;
          out_switched_nxt       = 1'b0;
          out_finished_nxt       = 1'b0;
          out_finished_index_nxt = '0;
          if (arrived_count_r >= CNT_W'(MAX_TASKS)) begin
            out_rejected_nxt   = 1'b1;
            out_task_index_nxt = '0;
            out_task_valid_nxt = 1'b0;
          end else begin
            out_rejected_nxt   = 1'b0;
            out_task_index_nxt = OUT_IDX_W'(arrived_count_r);
            out_task_valid_nxt = 1'b1;
            rem_we    = 1'b1;
            rem_waddr = arrived_count_r[IDX_W-1:0];
            rem_wdata = burst_sat;
            if (q_count_r < CNT_W'(MAX_TASKS)) begin
              q_we        = 1'b1;
              q_waddr     = q_tail_r;
              q_wdata     = arrived_count_r[IDX_W-1:0];
              q_tail_nxt  = wrap_inc(q_tail_r);
              q_count_nxt = q_count_r + 1'b1;
            end
            arrived_count_nxt = arrived_count_r + 1'b1;
          end
        end else if (start) begin
          // tick: dispatch on policy
          rotated_nxt  = 1'b0;
          scan_cnt_nxt = '0;
          rd_pend_nxt  = 1'b0;
          found_nxt    = 1'b0;
          if (policy_r == POL_RR) begin
            state_nxt = ST_RR_CHK;
          end else if (policy_r == POL_SJF && running_valid_r) begin
            sel_nxt   = running_task_r;
            state_nxt = ST_RD_SEL;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read a cycle, compare the previous read
        if (scan_cnt_r < arrived_count_r) begin
          rem_re       = 1'b1;
          rem_raddr    = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r && rem_rd_r != '0 &&
            (!found_r || (policy_r != POL_FCFS && rem_rd_r < best_r))) begin
          found_nxt = 1'b1;
          best_nxt  = rem_rd_r;
          sel_nxt   = rd_idx_r;
        end
        if (scan_cnt_r == arrived_count_r && !rd_pend_r) begin
          state_nxt = found_r ? ST_RD_SEL : ST_EMPTY;
        end
      end

      ST_RD_SEL: begin
        rem_re    = 1'b1;
        rem_raddr = sel_r;
        state_nxt = ST_DEC;
      end

      ST_DEC: begin
        // run one unit of the chosen task
        rem_we    = 1'b1;
        rem_waddr = sel_r;
        rem_wdata = dec_rem;
        if (policy_r == POL_RR && qcount_r != QCOUNT_MAX) begin
          qcount_nxt = qcount_r + 1'b1;
        end
        out_valid_nxt      = 1'b1;
        out_task_index_nxt = OUT_IDX_W'(sel_r);
        out_task_valid_nxt = 1'b1;
        out_switched_nxt   = !running_valid_r || (sel_r != running_task_r);
        out_rejected_nxt   = 1'b0;
        if (dec_rem == '0) begin
          out_finished_nxt       = 1'b1;
          out_finished_index_nxt = OUT_IDX_W'(sel_r);
          running_valid_nxt      = 1'b0;
        end else begin
          out_finished_nxt       = 1'b0;
          out_finished_index_nxt = '0;
          running_task_nxt       = sel_r;
          running_valid_nxt      = 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_EMPTY: begin
        // nothing to run
        out_valid_nxt          = 1'b1;
        out_task_index_nxt     = '0;
        out_task_valid_nxt     = 1'b0;
        out_switched_nxt       = running_valid_r;
        out_finished_nxt       = 1'b0;
        out_finished_index_nxt = '0;
        out_rejected_nxt       = 1'b0;
        running_valid_nxt      = 1'b0;
        state_nxt              = ST_IDLE;
      end

      ST_RR_CHK: begin
        if (q_count_r == '0) begin
          qcount_nxt = '0;
          state_nxt  = ST_EMPTY;
        end else begin
          q_re      = 1'b1;
          q_raddr   = q_head_r;
          state_nxt = ST_RR_QW;
        end
      end

      ST_RR_QW: begin
        rem_re    = 1'b1;
        rem_raddr = q_rd_r;
        state_nxt = ST_RR_RW;
      end

      ST_RR_RW: begin
        if (rem_rd_r == '0) begin
          // finished head leaves the queue
          q_head_nxt  = wrap_inc(q_head_r);
          q_count_nxt = q_count_r - 1'b1;
          state_nxt   = ST_RR_CHK;
        end else if (rotated_r) begin
          sel_nxt   = q_rd_r;
          state_nxt = ST_DEC;
        end else if (running_valid_r && q_rd_r == running_task_r) begin
          if (qcount_r >= quantum_r) begin
            // quantum used up: head moves to the tail
            q_head_nxt  = wrap_inc(q_head_r);
            q_we        = 1'b1;
            q_waddr     = q_tail_r;
            q_wdata     = q_rd_r;
            q_tail_nxt  = wrap_inc(q_tail_r);
            qcount_nxt  = '0;
            rotated_nxt = 1'b1;
            state_nxt   = ST_RR_CHK;
          end else begin
            sel_nxt   = q_rd_r;
            state_nxt = ST_DEC;
          end
        end else begin
          qcount_nxt = '0;
          sel_nxt    = q_rd_r;
          state_nxt  = ST_DEC;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      policy_r             <= POL_FCFS;
      quantum_r            <= QUANTUM_RESET;
      arrived_count_r      <= '0;
      q_head_r             <= '0;
      q_tail_r             <= '0;
      q_count_r            <= '0;
      qcount_r             <= '0;
      running_task_r       <= '0;
      running_valid_r      <= 1'b0;
      scan_cnt_r           <= '0;
      rd_pend_r            <= 1'b0;
      rd_idx_r             <= '0;
      found_r              <= 1'b0;
      best_r               <= '0;
      sel_r                <= '0;
      rotated_r            <= 1'b0;
      out_valid_r          <= 1'b0;
      out_task_index_r     <= '0;
      out_task_valid_r     <= 1'b0;
      out_switched_r       <= 1'b0;
      out_finished_r       <= 1'b0;
      out_finished_index_r <= '0;
      out_rejected_r       <= 1'b0;
    end else begin
      state_r              <= state_nxt;
      policy_r             <= policy_nxt;
      quantum_r            <= quantum_nxt;
      arrived_count_r      <= arrived_count_nxt;
      q_head_r             <= q_head_nxt;
      q_tail_r             <= q_tail_nxt;
      q_count_r            <= q_count_nxt;
      qcount_r             <= qcount_nxt;
      running_task_r       <= running_task_nxt;
      running_valid_r      <= running_valid_nxt;
      scan_cnt_r           <= scan_cnt_nxt;
      rd_pend_r            <= rd_pend_nxt;
      rd_idx_r             <= rd_idx_nxt;
      found_r              <= found_nxt;
      best_r               <= best_nxt;
      sel_r                <= sel_nxt;
      rotated_r            <= rotated_nxt;
      out_valid_r          <= out_valid_nxt;
      out_task_index_r     <= out_task_index_nxt;
      out_task_valid_r     <= out_task_valid_nxt;
      out_switched_r       <= out_switched_nxt;
      out_finished_r       <= out_finished_nxt;
      out_finished_index_r <= out_finished_index_nxt;
      out_rejected_r       <= out_rejected_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_task_index     = out_task_index_r;
  assign out_task_valid     = out_task_valid_r;
  assign out_switched       = out_switched_r;
  assign out_finished       = out_finished_r;
  assign out_finished_index = out_finished_index_r;
  assign out_rejected       = out_rejected_r;

  // checks
  `ASSERT_NXT(a_accept_progress, start && !busy, busy || out_valid,
              "accepted request stalled")
  `ASSERT_IMP(a_fin_matches, out_valid && out_finished,
              out_task_valid && out_finished_index == out_task_index,
              "finish does not match task run")
  `ASSERT_IMP(a_queue_bound, 1'b1, q_count_r <= arrived_count_r,
              "ready queue holds more than arrived")
  `ASSERT_IMP(a_running_known, running_valid_r, running_task_r < arrived_count_r,
              "running task never arrived")

endmodule
